FILE: rtl/core/itda_pkg.sv
// shared types, constants and tables for the decimal ascii converter
`timescale 1ns / 1ps
`default_nettype none

package itda_pkg;

    localparam int VALUE_BITS = 32;
    localparam int IN_VALUE_W = 32;
    localparam int CHAR_W     = 8;
    localparam int WIDE_W     = VALUE_BITS + 4;
    localparam int EXT_W      = (VALUE_BITS > IN_VALUE_W) ? VALUE_BITS : IN_VALUE_W;

    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'd48;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'd45;

    typedef logic [WIDE_W-1:0] wide_t;

    // number of decimal digits of the largest unsigned word
    function automatic int count_digits();
        wide_t maxv;
        wide_t p;
        int    n;
        maxv = WIDE_W'({VALUE_BITS{1'b1}});
        p    = WIDE_W'(1);
        n    = 0;
        for (int i = 0; i < 21; i++) begin
            if (p <= maxv) begin
                n = n + 1;
                p = p * WIDE_W'(10);
            end
        end
        return n;
    endfunction

    localparam int NUM_DIGITS = count_digits();
    localparam int EXP_W      = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;

    // d * 10^e for every digit position e and digit d
    typedef logic [NUM_DIGITS-1:0][9:0][WIDE_W-1:0] mult_table_t;

    function automatic mult_table_t build_mult_table();
        mult_table_t t;
        wide_t       p;
        p = WIDE_W'(1);
        for (int e = 0; e < NUM_DIGITS; e++) begin
            for (int d = 0; d < 10; d++) begin
                t[e][d] = p * WIDE_W'(d);
            end
            p = p * WIDE_W'(10);
        end
        return t;
    endfunction

    localparam mult_table_t MULT_TABLE = build_mult_table();

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [IN_VALUE_W-1:0] value;
        logic                  kind;
    } req_t;

    typedef struct packed {
        logic [CHAR_W-1:0] ascii_char;
        logic              last;
    } rsp_t;

    // classified number waiting for conversion
    typedef struct packed {
        logic                  neg;
        logic [VALUE_BITS-1:0] mag;
        logic [EXP_W-1:0]      top_exp;
    } job_t;

endpackage

`default_nettype wire

FILE: rtl/core/itda_front.sv
// front end: sign, magnitude and digit count of one request
`timescale 1ns / 1ps
`default_nettype none

module itda_front (
    input  var itda_pkg::req_t req,
    output var itda_pkg::job_t job
);

    logic [itda_pkg::EXT_W-1:0]      v_ext;
    logic [itda_pkg::VALUE_BITS-1:0] v;
    logic                            neg;
    logic [itda_pkg::VALUE_BITS-1:0] mag;
    itda_pkg::wide_t                 mag_w;
    logic [itda_pkg::NUM_DIGITS-1:0] ge;

    assign v_ext = itda_pkg::EXT_W'(req.value);
    assign v     = v_ext[itda_pkg::VALUE_BITS-1:0];
    assign neg   = req.kind & v[itda_pkg::VALUE_BITS-1];
    assign mag   = neg ? (~v + itda_pkg::VALUE_BITS'(1)) : v;
    assign mag_w = itda_pkg::WIDE_W'(mag);

    // ge[k]: magnitude has more than k digits, for k from 1 up; ge[0] is held low
    always_comb
    begin
        ge[0] = 1'b0;
        for (int k = 1; k < itda_pkg::NUM_DIGITS; k++) begin
            ge[k] = (mag_w >= itda_pkg::MULT_TABLE[k][1]);
        end
    end

    always_comb
    begin
        job.neg     = neg;
        job.mag     = mag;
        job.top_exp = itda_pkg::EXP_W'($countones(ge));
    end

endmodule

`default_nettype wire

FILE: rtl/core/itda_queue.sv
// short queue between the front end and the digit engine
`timescale 1ns / 1ps
`default_nettype none

module itda_queue (
    input  var logic           clk,
    input  var logic           rst_n,
    input  var logic           push,
    input  var itda_pkg::job_t push_job,
    output var logic           full,
    input  var logic           pop,
    output var itda_pkg::job_t pop_job,
    output var logic           not_empty
);

    itda_pkg::job_t                entry_reg [itda_pkg::QUEUE_DEPTH];
    logic [itda_pkg::QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [itda_pkg::QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [itda_pkg::QCNT_W-1:0]   count_reg, count_next;

    assign full      = (count_reg == itda_pkg::QCNT_W'(itda_pkg::QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_job   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = wr_ptr_reg + itda_pkg::QPTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = rd_ptr_reg + itda_pkg::QPTR_W'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + itda_pkg::QCNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - itda_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/itda_back.sv
// digit engine: emits sign and digits, most significant first
`timescale 1ns / 1ps
`default_nettype none

module itda_back (
    input  var logic           clk,
    input  var logic           rst_n,
    input  var logic           job_valid,
    input  var itda_pkg::job_t job,
    output var logic           job_pop,
    output var logic           rsp_valid,
    input  var logic           rsp_stall,
    output var itda_pkg::rsp_t rsp
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SIGN,
        ST_DIGIT
    } state_t;

    state_t                          state_reg, state_next;
    logic [itda_pkg::VALUE_BITS-1:0] mag_reg, mag_next;
    logic [itda_pkg::EXP_W-1:0]      exp_reg, exp_next;
    logic                            rsp_valid_reg, rsp_valid_next;
    itda_pkg::rsp_t                  rsp_reg, rsp_next;

    logic                            advance;
    itda_pkg::wide_t                 mag_w;
    logic [9:1]                      ge;
    logic [3:0]                      digit;
    logic [itda_pkg::VALUE_BITS-1:0] rest;

    assign advance = !rsp_valid_reg || !rsp_stall;
    assign job_pop = advance && (state_reg == ST_IDLE) && job_valid;

    // current digit: largest d with d * 10^exp not above the magnitude
    assign mag_w = itda_pkg::WIDE_W'(mag_reg);
    always_comb
    begin
        for (int d = 1; d < 10; d++) begin
            ge[d] = (mag_w >= itda_pkg::MULT_TABLE[exp_reg][d]);
        end
    end
    assign digit = 4'($countones(ge));
    assign rest  = mag_reg - itda_pkg::VALUE_BITS'(itda_pkg::MULT_TABLE[exp_reg][digit]);

    always_comb
    begin
        state_next     = state_reg;
        mag_next       = mag_reg;
        exp_next       = exp_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        if (advance) begin
            rsp_valid_next = 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (job_valid) begin
                        mag_next   = job.mag;
                        exp_next   = job.top_exp;
                        state_next = job.neg ? ST_SIGN : ST_DIGIT;
                    end
                end
                ST_SIGN:
                begin
                    rsp_valid_next      = 1'b1;
                    rsp_next.ascii_char = itda_pkg::CH_MINUS;
                    rsp_next.last       = 1'b0;
                    state_next          = ST_DIGIT;
                end
                ST_DIGIT:
                begin
                    rsp_valid_next      = 1'b1;
                    rsp_next.ascii_char = itda_pkg::CH_ZERO + {4'b0000, digit};
                    rsp_next.last       = (exp_reg == '0);
                    mag_next            = rest;
                    if (exp_reg == '0) begin
                        state_next = ST_IDLE;
                    end else begin
                        exp_next = exp_reg - itda_pkg::EXP_W'(1);
                    end
                end
                default:
                begin
                    state_next = ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= ST_IDLE;
            mag_reg       <= '0;
            exp_reg       <= '0;
            rsp_valid_reg <= 1'b0;
            rsp_reg       <= '0;
        end else begin
            state_reg     <= state_next;
            mag_reg       <= mag_next;
            exp_reg       <= exp_next;
            rsp_valid_reg <= rsp_valid_next;
            rsp_reg       <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

`default_nettype wire

FILE: rtl/core/int_to_decimal_ascii_unit.sv
// top level of the integer to decimal ascii converter
// a request is registered in the queue, then loaded by the digit engine, whose response is registered
// throughput: set by the digit engine, which loads a number only when idle, then emits one
//   character per cycle while the response is not stalled
// up to two requests wait in the queue while the engine works, so they are still taken under stall
// reset clears the queue, the engine state and the response valid; no clearing pass
`timescale 1ns / 1ps
`default_nettype none

module int_to_decimal_ascii_unit (
    input  var logic           clk,
    input  var logic           rst_n,
    input  var logic           req_valid,
    output var logic           req_stall,
    input  var itda_pkg::req_t req,
    output var logic           rsp_valid,
    input  var logic           rsp_stall,
    output var itda_pkg::rsp_t rsp
);

    itda_pkg::job_t front_job;
    itda_pkg::job_t queued_job;
    logic           q_full;
    logic           q_not_empty;
    logic           q_pop;
    logic           q_push;

    // request is taken whenever the queue has room
    assign req_stall = q_full;
    assign q_push    = req_valid && !q_full;

    // front end: sign, magnitude and number of digits
    itda_front u_front (
        .req (req),
        .job (front_job)
    );

    // decouples request side from the digit engine
    itda_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_job  (front_job),
        .full      (q_full),
        .pop       (q_pop),
        .pop_job   (queued_job),
        .not_empty (q_not_empty)
    );

    // digit engine with registered response
    itda_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (q_not_empty),
        .job       (queued_job),
        .job_pop   (q_pop),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

endmodule

`default_nettype wire

FILE: rtl/core/itda_checker.sv
// port level checks for the decimal ascii converter, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module itda_checker (
    input var logic           clk,
    input var logic           rst_n,
    input var logic           req_valid,
    input var logic           req_stall,
    input var logic           rsp_valid,
    input var logic           rsp_stall,
    input var itda_pkg::rsp_t rsp
);

    logic       req_take;
    logic       rsp_take;
    logic [2:0] pend_reg, pend_next;
    logic       after_minus_reg, after_minus_next;

    assign req_take = req_valid && !req_stall;
    assign rsp_take = rsp_valid && !rsp_stall;

    always_comb
    begin
        pend_next = pend_reg;
        if (req_take && !(rsp_take && rsp.last)) begin
            pend_next = pend_reg + 3'd1;
        end else if (!req_take && rsp_take && rsp.last) begin
            pend_next = pend_reg - 3'd1;
        end
        after_minus_next = after_minus_reg;
        if (rsp_take) begin
            after_minus_next = (rsp.ascii_char == itda_pkg::CH_MINUS);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pend_reg        <= '0;
            after_minus_reg <= 1'b0;
        end else begin
            pend_reg        <= pend_next;
            after_minus_reg <= after_minus_next;
        end
    end

    // stalled response holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("response changed under stall");

    // no response without an open request
    a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> pend_reg != 3'd0)
        else $error("response without request");

    // a minus sign never ends a number
    a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.ascii_char == itda_pkg::CH_MINUS |-> !rsp.last)
        else $error("minus flagged last");

    // after a minus comes neither a zero nor another minus
    a_after_minus: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && after_minus_reg |->
            rsp.ascii_char != itda_pkg::CH_ZERO && rsp.ascii_char != itda_pkg::CH_MINUS)
        else $error("bad character after minus");

endmodule

bind int_to_decimal_ascii_unit itda_checker u_itda_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);

`default_nettype wire

FILE: tb/tb_int_to_decimal_ascii_unit.sv
// testbench for the integer to decimal ascii converter: directed table, then random words
`timescale 1ns / 1ps

module tb_int_to_decimal_ascii_unit;

    // one row of the directed table; an empty text means the predictor supplies the answer
    typedef struct {
        logic [itda_pkg::IN_VALUE_W-1:0] value;
        logic                            kind;
        string                           text;
    } word_row_t;

    localparam int NUM_ROWS     = 21;
    localparam int RANDOM_WORDS = 89;

    // word kinds as the block reads them
    localparam logic KIND_UNSIGNED = 1'b0;
    localparam logic KIND_SIGNED   = 1'b1;

    logic           clk       = 1'b0;
    logic           rst_n     = 1'b0;
    logic           req_valid = 1'b0;
    logic           req_stall;
    itda_pkg::req_t req       = '0;
    logic           rsp_valid;
    logic           rsp_stall = 1'b0;
    itda_pkg::rsp_t rsp;

    // characters still owed by the block, oldest first
    itda_pkg::rsp_t expected_chars[$];
    int   mismatch_count = 0;

    // sender pacing: items left in the current burst
    int   burst_left = 0;

    // receiver stall pattern state
    int   stall_cycle = 0;
    int   stall_mode  = 0;

    word_row_t word_rows [NUM_ROWS];

    int_to_decimal_ascii_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always #5 clk = ~clk;

    // expected text of one word: optional minus, then digits, most significant first
    function automatic void predict_text(input itda_pkg::req_t r);
        logic            neg;
        logic [31:0]     mag;
        logic [3:0]      digs [10];
        int              nd;
        neg = (r.kind == KIND_SIGNED) && r.value[31];
        // two's complement magnitude; the signed minimum maps onto 2^31 exactly
        mag = neg ? (~r.value + 32'd1) : r.value;
        nd  = 0;
        do begin
            digs[nd] = 4'(mag % 32'd10);
            mag      = mag / 32'd10;
            nd++;
        end while (mag != 32'd0);
        if (neg)
            expected_chars.push_back(itda_pkg::rsp_t'{ascii_char: itda_pkg::CH_MINUS,
                                                      last: 1'b0});
        for (int i = nd - 1; i >= 0; i--)
            expected_chars.push_back(itda_pkg::rsp_t'{
                ascii_char: itda_pkg::CH_ZERO + 8'(digs[i]),
                last: (i == 0)});
    endfunction

    // typed-in text from the table becomes the expectation directly
    function automatic void queue_text(input string text);
        for (int i = 0; i < text.len(); i++)
            expected_chars.push_back(itda_pkg::rsp_t'{ascii_char: text[i],
                                                      last: (i == text.len() - 1)});
    endfunction

    // start of each item: random bursts with random gaps between them
    task automatic pace_sender();
        int gap;
        if (burst_left == 0) begin
            // every so often a long burst so stretches without idling occur
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 20)
                                                     : $urandom_range(1, 6);
            gap = $urandom_range(0, 10);
            if (gap != 0) begin
                req_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
    endtask

    // present one request and hold it until taken; called at a rising edge
    task automatic send_request(input itda_pkg::req_t r, input string text);
        logic taken;
        req       <= r;
        req_valid <= 1'b1;
        taken = 1'b0;
        while (!taken) begin
            // stall is settled at the falling edge and decides the coming rising edge
            @(negedge clk);
            taken = !req_stall;
            if (taken) begin
                if (text.len() != 0)
                    queue_text(text);
                else
                    predict_text(r);
            end
            @(posedge clk);
        end
    endtask

    // hold off the sender until every owed character has come back
    task automatic drain_output();
        req_valid <= 1'b0;
        while (expected_chars.size() != 0)
            @(posedge clk);
    endtask

    // random word, shaped toward digit-count edges and the sign boundary
    function automatic itda_pkg::req_t random_word();
        itda_pkg::req_t r;
        logic [31:0]    p10;
        int             e;
        r.kind = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 5))
            0: r.value = $urandom();
            1: r.value = $urandom_range(0, 99);
            2: begin
                // a power of ten, one below or one above
                e   = $urandom_range(0, 9);
                p10 = 32'd1;
                repeat (e) p10 = p10 * 32'd10;
                r.value = p10 + 32'($urandom_range(0, 2)) - 32'd1;
            end
            3: r.value = 32'h7fff_fff0 + 32'($urandom_range(0, 31));
            4: r.value = {1'b1, 31'($urandom())};
            default: r.value = 32'd0 - 32'($urandom_range(1, 100));
        endcase
        return r;
    endfunction

    // receiver stall pattern: free running, coin flips, or stalled unless the cycle counter is a multiple of four
    always @(posedge clk) begin
        stall_cycle <= stall_cycle + 1;
        if (stall_cycle % 97 == 0)
            stall_mode <= $urandom_range(0, 2);
        case (stall_mode)
            0:       rsp_stall <= 1'b0;
            1:       rsp_stall <= 1'($urandom_range(0, 1));
            default: rsp_stall <= (stall_cycle % 4 != 0);
        endcase
    end

    // response checker; values are stable at the falling edge ahead of the accepting edge
    always @(negedge clk) begin
        itda_pkg::rsp_t want;
        if (rst_n && rsp_valid && !rsp_stall) begin
            if (expected_chars.size() == 0) begin
                if (mismatch_count < 10)
                    $display("unexpected character: char %0d last %0b",
                             rsp.ascii_char, rsp.last);
                mismatch_count++;
            end else begin
                want = expected_chars.pop_front();
                if (rsp.ascii_char !== want.ascii_char || rsp.last !== want.last) begin
                    if (mismatch_count < 10)
                        $display("mismatch: char exp %0d got %0d, last exp %0b got %0b",
                                 want.ascii_char, rsp.ascii_char, want.last, rsp.last);
                    mismatch_count++;
                end
            end
        end
    end

    // generous limit, far above the slowest correct run
    initial begin
        #2_000_000;
        $display("tb_int_to_decimal_ascii_unit: errors");
        $finish;
    end

    initial begin
        word_rows = '{
            '{32'd0,          KIND_UNSIGNED, "0"},
            '{32'd0,          KIND_SIGNED,   "0"},
            '{32'd1,          KIND_UNSIGNED, "1"},
            '{32'd9,          KIND_SIGNED,   "9"},
            '{32'd10,         KIND_UNSIGNED, "10"},
            '{32'hffff_ffff,  KIND_UNSIGNED, "4294967295"},
            '{32'hffff_ffff,  KIND_SIGNED,   "-1"},
            '{32'h8000_0000,  KIND_SIGNED,   "-2147483648"},
            '{32'h8000_0000,  KIND_UNSIGNED, "2147483648"},
            '{32'h7fff_ffff,  KIND_SIGNED,   "2147483647"},
            '{32'h7fff_ffff,  KIND_UNSIGNED, "2147483647"},
            '{32'h8000_0001,  KIND_SIGNED,   "-2147483647"},
            '{32'hffff_fff6,  KIND_SIGNED,   "-10"},
            '{32'd1000000000, KIND_UNSIGNED, "1000000000"},
            '{32'hffff_fff6,  KIND_UNSIGNED, ""},
            '{32'd999999999,  KIND_SIGNED,   ""},
            '{32'd123456789,  KIND_SIGNED,   ""},
            '{32'haaaa_aaaa,  KIND_SIGNED,   ""},
            '{32'h5555_5555,  KIND_UNSIGNED, ""},
            '{32'd100,        KIND_SIGNED,   ""},
            '{32'hdead_beef,  KIND_UNSIGNED, ""}
        };

        // single reset at the start of the run
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed words
        for (int i = 0; i < NUM_ROWS; i++) begin
            pace_sender();
            send_request(itda_pkg::req_t'{value: word_rows[i].value, kind: word_rows[i].kind},
                         word_rows[i].text);
        end

        // let the block empty completely before the random part
        drain_output();

        for (int i = 0; i < RANDOM_WORDS; i++) begin
            // a second full drain halfway through
            if (i == RANDOM_WORDS / 2)
                drain_output();
            pace_sender();
            send_request(random_word(), "");
        end

        req_valid <= 1'b0;
        while (expected_chars.size() != 0)
            @(posedge clk);
        // wait on to catch stray characters
        repeat (20) @(posedge clk);

        if (mismatch_count == 0 && expected_chars.size() == 0)
            $display("tb_int_to_decimal_ascii_unit: clean");
        else
            $display("tb_int_to_decimal_ascii_unit: errors");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/core/itda_pkg.sv
rtl/core/itda_front.sv
rtl/core/itda_queue.sv
rtl/core/itda_back.sv
rtl/core/int_to_decimal_ascii_unit.sv
rtl/core/itda_checker.sv
tb/tb_int_to_decimal_ascii_unit.sv
